[hw/rtl/slu_pkg.sv]
// ----------------------------------------------------------------------------
// slu_pkg
// Shared types and constants for the serial line unit register block.
// ----------------------------------------------------------------------------
package slu_pkg;

    localparam logic [15:0] CONSOLE_BASE = 16'o177560;
    localparam logic [15:0] LTC_OFFSET   = 16'o12;
    localparam logic [15:0] LTC_ADDR     = CONSOLE_BASE - LTC_OFFSET;
    localparam logic [7:0]  RX_DONE      = 8'o200;
    localparam logic [7:0]  RX_KEEP      = 8'h42;
    localparam logic [7:0]  TX_READY     = 8'o200;
    localparam logic [7:0]  TX_KEEP      = 8'h46;
    localparam logic [15:0] OFF_RX_DATA  = 16'd2;
    localparam logic [15:0] OFF_TX_STAT  = 16'd4;
    localparam logic [15:0] OFF_TX_DATA  = 16'd6;

    localparam int          PADDR_W      = 3;

    typedef enum logic [0:0] {
        REG_BASE_ADDRESS = 1'b0,
        REG_PORT_ENABLED = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        tx_can_accept;
        logic        rx_byte_valid;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        hit;
        logic        address_error;
        logic        tx_strobe;
        logic [7:0]  tx_byte;
    } result_t;

    typedef struct packed {
        logic [15:0] base_address;
        logic        port_enabled;
    } cfg_t;

endpackage

[hw/rtl/slu_cfg.sv]
// ----------------------------------------------------------------------------
// slu_cfg
// APB configuration registers: base address and port enable.
// ----------------------------------------------------------------------------
module slu_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output slu_pkg::cfg_t               cfg
);

    logic [15:0]       base_address_reg;
    logic              port_enabled_reg;
    logic              wr_en;
    slu_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = slu_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= slu_pkg::CONSOLE_BASE;
            port_enabled_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                slu_pkg::REG_BASE_ADDRESS: base_address_reg <= pwdata[15:0];
                slu_pkg::REG_PORT_ENABLED: port_enabled_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            slu_pkg::REG_BASE_ADDRESS: prdata = {16'd0, base_address_reg};
            slu_pkg::REG_PORT_ENABLED: prdata = {31'd0, port_enabled_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.base_address = base_address_reg;
    assign cfg.port_enabled = port_enabled_reg;

endmodule

[hw/rtl/slu_exec.sv]
// ----------------------------------------------------------------------------
// slu_exec
// Status and buffer registers with the decode and update logic for one
// transaction.
// ----------------------------------------------------------------------------
module slu_exec
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  slu_pkg::item_t   item,
    input  slu_pkg::cfg_t    cfg,
    output slu_pkg::result_t result
);

    logic [7:0]  rx_status_reg, rx_status_next;
    logic [7:0]  tx_status_reg, tx_status_next;
    logic [7:0]  rx_buffer_reg, rx_buffer_next;
    logic [15:0] a_rx_stat, a_rx_data, a_tx_stat, a_tx_data;
    logic        m_rx_stat, m_rx_data, m_tx_stat, m_tx_data, m_ltc, any_hit;

    assign a_rx_stat = cfg.base_address;
    assign a_rx_data = cfg.base_address + slu_pkg::OFF_RX_DATA;
    assign a_tx_stat = cfg.base_address + slu_pkg::OFF_TX_STAT;
    assign a_tx_data = cfg.base_address + slu_pkg::OFF_TX_DATA;

    assign m_rx_stat = (item.address == a_rx_stat);
    assign m_rx_data = (item.address == a_rx_data);
    assign m_tx_stat = (item.address == a_tx_stat);
    assign m_tx_data = (item.address == a_tx_data);
    assign m_ltc     = (cfg.base_address == slu_pkg::CONSOLE_BASE) &&
                       (item.address == slu_pkg::LTC_ADDR);
    assign any_hit   = m_rx_stat || m_rx_data || m_tx_stat || m_tx_data || m_ltc;

    always_comb
    begin
        rx_status_next = rx_status_reg;
        tx_status_next = tx_status_reg;
        rx_buffer_next = rx_buffer_reg;
        result         = '0;
        case (slu_pkg::cmd_t'(item.command))
            slu_pkg::CMD_READ:
            begin
                result.hit = any_hit;
                if (m_rx_stat)
                    result.read_data = {8'd0, rx_status_reg};
                else if (m_tx_stat)
                    result.read_data = {8'd0, tx_status_reg};
                else if (m_rx_data)
                begin
                    result.read_data = {8'd0, rx_buffer_reg};
                    rx_status_next   = rx_status_reg & slu_pkg::RX_KEEP;
                end
                else if (!m_tx_data)
                    result.address_error = 1'b1;
            end
            slu_pkg::CMD_WRITE:
            begin
                result.hit = any_hit;
                if (m_rx_stat)
                    rx_status_next = item.write_data[7:0] & slu_pkg::RX_KEEP;
                else if (m_tx_stat)
                    tx_status_next = item.write_data[7:0] & slu_pkg::TX_KEEP;
                else if (m_tx_data)
                begin
                    tx_status_next = tx_status_reg & slu_pkg::TX_KEEP;
                    if (cfg.port_enabled)
                    begin
                        result.tx_strobe = 1'b1;
                        result.tx_byte   = item.write_data[7:0];
                    end
                end
            end
            slu_pkg::CMD_TICK:
            begin
                if (cfg.port_enabled)
                begin
                    if (item.tx_can_accept)
                        tx_status_next = tx_status_reg | slu_pkg::TX_READY;
                    else
                        tx_status_next = tx_status_reg & ~slu_pkg::TX_READY;
                    if (item.rx_byte_valid && ((rx_status_reg & slu_pkg::RX_DONE) == 8'd0))
                    begin
                        rx_buffer_next = item.rx_byte;
                        rx_status_next = rx_status_reg | slu_pkg::RX_DONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_status_reg <= 8'd0;
            tx_status_reg <= slu_pkg::TX_READY;
            rx_buffer_reg <= 8'd0;
        end
        else if (fire)
        begin
            rx_status_reg <= rx_status_next;
            tx_status_reg <= tx_status_next;
            rx_buffer_reg <= rx_buffer_next;
        end
    end

endmodule

[hw/rtl/serial_line_unit_registers_core.sv]
// ----------------------------------------------------------------------------
// serial_line_unit_registers_core
// Datapath: an accepted transaction is held in the input register, then its
// result in the result register. Throughput: one transaction per cycle,
// set by the single execute stage, unless out_stall holds the result.
// Reset: rst_n clears pipeline valids; receive status and buffer to zero,
// transmit status to ready, base address to the console base, port enabled.
// ----------------------------------------------------------------------------
module serial_line_unit_registers_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  command,
    input  logic [15:0]                 address,
    input  logic [15:0]                 write_data,
    input  logic                        tx_can_accept,
    input  logic                        rx_byte_valid,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 read_data,
    output logic                        hit,
    output logic                        address_error,
    output logic                        tx_strobe,
    output logic [7:0]                  tx_byte,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    slu_pkg::cfg_t    cfg;
    slu_pkg::item_t   item_reg;
    slu_pkg::result_t res_comb, res_reg;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             res_free, fire, take;

    slu_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slu_exec u_exec
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    assign res_free = !out_valid_reg || !out_stall;
    assign fire     = item_valid_reg && res_free;
    assign in_stall = item_valid_reg && !res_free;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
                item_valid_reg <= 1'b1;
            else if (fire)
                item_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command       <= command;
            item_reg.address       <= address;
            item_reg.write_data    <= write_data;
            item_reg.tx_can_accept <= tx_can_accept;
            item_reg.rx_byte_valid <= rx_byte_valid;
            item_reg.rx_byte       <= rx_byte;
        end
        if (fire)
            res_reg <= res_comb;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = res_reg.read_data;
    assign hit           = res_reg.hit;
    assign address_error = res_reg.address_error;
    assign tx_strobe     = res_reg.tx_strobe;
    assign tx_byte       = res_reg.tx_byte;

endmodule
